### hdl/cts_pkg.sv
// Shared types, codes and helpers for the complex tridiagonal solver.
// No dependencies; every other file in hdl imports this package.
package cts_pkg;

	// Complex word, signed fixed point
	typedef struct packed {
		logic signed [31:0] re;
		logic signed [31:0] im;
	} cplx_t;

	// One matrix row request
	typedef struct packed {
		logic signed [31:0] sub_re;
		logic signed [31:0] sub_im;
		logic signed [31:0] diag_re;
		logic signed [31:0] diag_im;
		logic signed [31:0] super_re;
		logic signed [31:0] super_im;
		logic signed [31:0] rhs_re;
		logic signed [31:0] rhs_im;
		logic               row_last;
	} row_t;

	// One solution element
	typedef struct packed {
		logic signed [31:0] sol_re;
		logic signed [31:0] sol_im;
		logic [5:0]         sol_index;
		logic               sol_last;
		logic               singular;
	} sol_t;

	typedef enum logic {
		OP_MSUB,
		OP_DIV
	} alu_op_t;

	// Arithmetic unit request: MSUB gives c - a*b, DIV gives a / b
	typedef struct packed {
		logic    start;
		alu_op_t op;
		cplx_t   a;
		cplx_t   b;
		cplx_t   c;
	} alu_req_t;

	typedef struct packed {
		logic  done;
		logic  zdiv;
		cplx_t res;
	} alu_rsp_t;

	typedef enum logic [2:0] {
		ALU_IDLE,
		ALU_MUL,
		ALU_DRAIN,
		ALU_PREP,
		ALU_DIV,
		ALU_FIN
	} alu_state_t;

	typedef enum logic [3:0] {
		C_IDLE,
		C_PIV,
		C_RHS,
		C_DIAG,
		C_WR,
		C_BX,
		C_BUPD,
		C_ERD,
		C_EOUT
	} ctl_state_t;

	// Saturate a wide signed value to 32 bits
	function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
		logic signed [31:0] r;
		if (v > 66'sd2147483647)
			r = 32'sh7fffffff;
		else if (v < -66'sd2147483648)
			r = 32'sh80000000;
		else
			r = v[31:0];
		return r;
	endfunction

	// Sign-extend a 32-bit word to the accumulator width
	function automatic logic signed [65:0] sx66(input logic signed [31:0] v);
		return $signed({{34{v[31]}}, v});
	endfunction

endpackage

### hdl/cts_alu.sv
// Shared complex arithmetic unit: one 32x32 multiplier with accumulators
// and a one-bit-per-cycle restoring divider. Depends on cts_pkg.
module cts_alu #(
	parameter int FRAC_BITS = 24
) (
	input  logic              clk,
	input  logic              arst_n,
	input  cts_pkg::alu_req_t req,
	output cts_pkg::alu_rsp_t rsp
);
	import cts_pkg::*;

	localparam int QW = 33;
	localparam int RW = 64 + QW + 1;
	localparam logic [5:0] TOP = 6'(QW);

	alu_state_t state_q, state_d;
	alu_op_t    op_q;
	cplx_t      a_q, b_q, c_q;
	logic [2:0] step_q, tag_s1;
	logic       vld_s1;
	logic signed [63:0] p_s1;
	logic signed [65:0] acc0_q, acc1_q, acc2_q;
	logic [RW-1:0] rem_q, dv_q;
	logic [QW-1:0] q_q, q_n;
	logic [5:0]    cnt_q;
	logic          part_q, neg_q, zdiv_q;
	logic signed [31:0] qre_q, qim_q, part_val;
	logic signed [31:0] mx, my;
	logic signed [63:0] prod;
	logic signed [65:0] sh, pw;
	logic [2:0] last_step;
	logic       ge, fin_part, den_zero;

	function automatic logic [63:0] mag64(input logic signed [65:0] v);
		logic signed [65:0] t;
		t = v[65] ? -v : v;
		return t[63:0];
	endfunction

	// Sign and saturate a quotient magnitude
	function automatic logic signed [31:0] qfix(input logic [QW-1:0] q, input logic ovf,
			input logic neg);
		logic signed [31:0] r;
		if (ovf)
			r = neg ? 32'sh80000000 : 32'sh7fffffff;
		else if (neg)
			r = (q[QW-1:31] != '0) ? 32'sh80000000 : -$signed({1'b0, q[30:0]});
		else
			r = (q[QW-1:31] != '0) ? 32'sh7fffffff : $signed({1'b0, q[30:0]});
		return r;
	endfunction

	// Select multiplier operands for the current step
	always_comb begin
		mx = a_q.re;
		my = b_q.re;
		if (op_q == OP_MSUB) begin
			case (step_q)
				3'd0: begin mx = a_q.re; my = b_q.re; end
				3'd1: begin mx = a_q.im; my = b_q.im; end
				3'd2: begin mx = a_q.re; my = b_q.im; end
				3'd3: begin mx = a_q.im; my = b_q.re; end
				default: begin mx = a_q.re; my = b_q.re; end
			endcase
		end else begin
			case (step_q)
				3'd0: begin mx = b_q.re; my = b_q.re; end
				3'd1: begin mx = b_q.im; my = b_q.im; end
				3'd2: begin mx = a_q.re; my = b_q.re; end
				3'd3: begin mx = a_q.im; my = b_q.im; end
				3'd4: begin mx = a_q.im; my = b_q.re; end
				3'd5: begin mx = a_q.re; my = b_q.im; end
				default: begin mx = a_q.re; my = b_q.re; end
			endcase
		end
	end

	assign prod      = mx * my;
	assign pw        = $signed({{2{p_s1[63]}}, p_s1});
	assign sh        = pw >>> FRAC_BITS;
	assign last_step = (op_q == OP_DIV) ? 3'd5 : 3'd3;
	assign den_zero  = (acc0_q == '0);

	// Divider compare and bit insertion
	assign ge       = (rem_q >= dv_q);
	assign q_n      = q_q | ((ge ? QW'(1) : QW'(0)) << cnt_q);
	assign fin_part = (state_q == ALU_DIV) && ((cnt_q == TOP && ge) || cnt_q == 6'd0);
	assign part_val = (cnt_q == TOP) ? qfix(q_q, 1'b1, neg_q) : qfix(q_n, 1'b0, neg_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ALU_IDLE;
		else
			state_q <= state_d;
	end

	// Next state and response
	always_comb begin
		state_d = state_q;
		case (state_q)
			ALU_IDLE:  if (req.start) state_d = ALU_MUL;
			ALU_MUL:   if (step_q == last_step) state_d = ALU_DRAIN;
			ALU_DRAIN: state_d = (op_q == OP_DIV) ? ALU_PREP : ALU_FIN;
			ALU_PREP:  state_d = den_zero ? ALU_FIN : ALU_DIV;
			ALU_DIV:   if (fin_part && part_q) state_d = ALU_FIN;
			ALU_FIN:   state_d = ALU_IDLE;
			default:   state_d = ALU_IDLE;
		endcase
		rsp.done = (state_q == ALU_FIN);
		rsp.zdiv = zdiv_q;
		if (op_q == OP_MSUB) begin
			rsp.res.re = sat32(sx66(c_q.re) - sx66(sat32(acc0_q)));
			rsp.res.im = sat32(sx66(c_q.im) - sx66(sat32(acc1_q)));
		end else begin
			rsp.res.re = qre_q;
			rsp.res.im = qim_q;
		end
	end

	// Control counters and flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
			vld_s1 <= 1'b0;
			cnt_q  <= '0;
			part_q <= 1'b0;
			zdiv_q <= 1'b0;
		end else begin
			vld_s1 <= (state_q == ALU_MUL);
			case (state_q)
				ALU_IDLE: begin
					step_q <= '0;
					zdiv_q <= 1'b0;
				end
				ALU_MUL: step_q <= step_q + 3'd1;
				ALU_PREP: begin
					zdiv_q <= den_zero;
					cnt_q  <= TOP;
					part_q <= 1'b0;
				end
				ALU_DIV: begin
					if (fin_part) begin
						cnt_q  <= TOP;
						part_q <= 1'b1;
					end else begin
						cnt_q <= cnt_q - 6'd1;
					end
				end
				default: ;
			endcase
		end
	end

	// Operands, products, accumulators and divider datapath
	always_ff @(posedge clk) begin
		p_s1   <= prod;
		tag_s1 <= step_q;
		if (state_q == ALU_IDLE && req.start) begin
			op_q   <= req.op;
			a_q    <= req.a;
			b_q    <= req.b;
			c_q    <= req.c;
			acc0_q <= '0;
			acc1_q <= '0;
			acc2_q <= '0;
		end
		if (vld_s1) begin
			if (op_q == OP_MSUB) begin
				case (tag_s1)
					3'd0:    acc0_q <= acc0_q + sh;
					3'd1:    acc0_q <= acc0_q - sh;
					default: acc1_q <= acc1_q + sh;
				endcase
			end else begin
				case (tag_s1)
					3'd0, 3'd1: acc0_q <= acc0_q + pw;
					3'd2, 3'd3: acc1_q <= acc1_q + pw;
					3'd4:       acc2_q <= acc2_q + pw;
					default:    acc2_q <= acc2_q - pw;
				endcase
			end
		end
		case (state_q)
			ALU_PREP: begin
				qre_q <= '0;
				qim_q <= '0;
				rem_q <= RW'(mag64(acc1_q)) << FRAC_BITS;
				dv_q  <= RW'(acc0_q[63:0]) << QW;
				neg_q <= acc1_q[65];
				q_q   <= '0;
			end
			ALU_DIV: begin
				if (fin_part) begin
					if (!part_q)
						qre_q <= part_val;
					else
						qim_q <= part_val;
					// load the imaginary part
					rem_q <= RW'(mag64(acc2_q)) << FRAC_BITS;
					dv_q  <= RW'(acc0_q[63:0]) << QW;
					neg_q <= acc2_q[65];
					q_q   <= '0;
				end else begin
					if (cnt_q != TOP) begin
						q_q <= q_n;
						if (ge)
							rem_q <= rem_q - dv_q;
					end
					dv_q <= dv_q >> 1;
				end
			end
			default: ;
		endcase
	end

endmodule

### hdl/complex_tridiagonal_solver.sv
// Complex tridiagonal solver, Thomas algorithm. After a row other than the
// first is accepted, row_stall stays high while it goes through one complex
// division (33 quotient bits per part) and two multiply-subtracts; the first
// row is only stored. The final row adds back substitution, a division per row
// and a multiply-subtract per row above row zero; results then leave last row
// first. Reset clears the sequencer, row count and singular flag.
module complex_tridiagonal_solver #(
	parameter int SIZE      = 64,
	parameter int FRAC_BITS = 24
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          row_valid,
	output logic          row_stall,
	input  cts_pkg::row_t row,
	output logic          sol_valid,
	input  logic          sol_stall,
	output cts_pkg::sol_t sol
);
	import cts_pkg::*;

	localparam int AW = $clog2(SIZE);

	ctl_state_t state_q, state_d;
	alu_req_t   req;
	alu_rsp_t   rsp;

	row_t    row_q;
	logic [AW-1:0] cnt_q, bi_q, rd_addr;
	logic    sing_q;
	cplx_t   prev_diag_q, prev_rhs_q, prev_sup_q, piv_q, nrhs_q, ndiag_q;
	cplx_t   cur_diag_q, cur_rhs_q, x_q;
	cplx_t   diag_rd_q, rhs_rd_q, sup_rd_q, sol_rd_q;
	cplx_t   row_sub, row_dia, row_sup, row_rhs;
	logic    end_sys;

	cplx_t diag_mem [SIZE];
	cplx_t rhs_mem  [SIZE];
	cplx_t sup_mem  [SIZE];
	cplx_t sol_mem  [SIZE];

	assign row_sub = '{re: row_q.sub_re, im: row_q.sub_im};
	assign row_dia = '{re: row_q.diag_re, im: row_q.diag_im};
	assign row_sup = '{re: row_q.super_re, im: row_q.super_im};
	assign row_rhs = '{re: row_q.rhs_re, im: row_q.rhs_im};
	assign rd_addr = bi_q - AW'(1);
	assign end_sys = row_q.row_last || (cnt_q == AW'(SIZE - 1));

	cts_alu #(.FRAC_BITS(FRAC_BITS)) u_alu (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= C_IDLE;
		else
			state_q <= state_d;
	end

	// Sequence the solve and drive the arithmetic unit
	always_comb begin
		state_d   = state_q;
		req.start = 1'b0;
		req.op    = OP_MSUB;
		req.a     = prev_rhs_q;
		req.b     = piv_q;
		req.c     = row_rhs;
		case (state_q)
			C_IDLE: begin
				if (row_valid)
					state_d = (cnt_q == '0) ? C_WR : C_PIV;
			end
			C_PIV: begin
				req.start = 1'b1;
				req.op    = OP_DIV;
				req.a     = row_sub;
				req.b     = prev_diag_q;
				if (rsp.done) state_d = C_RHS;
			end
			C_RHS: begin
				req.start = 1'b1;
				if (rsp.done) state_d = C_DIAG;
			end
			C_DIAG: begin
				req.start = 1'b1;
				req.a     = prev_sup_q;
				req.c     = row_dia;
				if (rsp.done) state_d = C_WR;
			end
			C_WR: state_d = end_sys ? C_BX : C_IDLE;
			C_BX: begin
				req.start = 1'b1;
				req.op    = OP_DIV;
				req.a     = cur_rhs_q;
				req.b     = cur_diag_q;
				if (rsp.done) state_d = (bi_q == '0) ? C_ERD : C_BUPD;
			end
			C_BUPD: begin
				req.start = 1'b1;
				req.a     = sup_rd_q;
				req.b     = x_q;
				req.c     = rhs_rd_q;
				if (rsp.done) state_d = C_BX;
			end
			C_ERD: state_d = C_EOUT;
			C_EOUT: begin
				if (!sol_stall) state_d = (bi_q == '0) ? C_IDLE : C_ERD;
			end
			default: state_d = C_IDLE;
		endcase
	end

	assign row_stall = (state_q != C_IDLE);
	assign sol_valid = (state_q == C_EOUT);

	always_comb begin
		sol.sol_re    = sol_rd_q.re;
		sol.sol_im    = sol_rd_q.im;
		sol.sol_index = 6'(bi_q);
		sol.sol_last  = (bi_q == '0);
		sol.singular  = sing_q;
	end

	// Row count, back-substitution index and singular flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			bi_q   <= '0;
			sing_q <= 1'b0;
		end else begin
			case (state_q)
				C_PIV, C_BX: if (rsp.done && rsp.zdiv) sing_q <= 1'b1;
				C_WR: begin
					if (end_sys)
						bi_q <= cnt_q;
					else
						cnt_q <= cnt_q + AW'(1);
				end
				C_BUPD: if (rsp.done) bi_q <= bi_q - AW'(1);
				default: ;
			endcase
			if (state_q == C_BX && rsp.done && bi_q == '0)
				bi_q <= cnt_q;
			if (state_q == C_EOUT && !sol_stall) begin
				if (bi_q == '0) begin
					cnt_q  <= '0;
					sing_q <= 1'b0;
				end else begin
					bi_q <= bi_q - AW'(1);
				end
			end
		end
	end

	// Hold the row and the working values
	always_ff @(posedge clk) begin
		case (state_q)
			C_IDLE: begin
				if (row_valid) begin
					row_q   <= row;
					ndiag_q <= '{re: row.diag_re, im: row.diag_im};
					nrhs_q  <= '{re: row.rhs_re, im: row.rhs_im};
				end
			end
			C_PIV:  if (rsp.done) piv_q <= rsp.res;
			C_RHS:  if (rsp.done) nrhs_q <= rsp.res;
			C_DIAG: if (rsp.done) ndiag_q <= rsp.res;
			C_WR: begin
				prev_diag_q <= ndiag_q;
				prev_rhs_q  <= nrhs_q;
				prev_sup_q  <= row_sup;
				cur_diag_q  <= ndiag_q;
				cur_rhs_q   <= nrhs_q;
			end
			C_BX: if (rsp.done) x_q <= rsp.res;
			C_BUPD: begin
				if (rsp.done) begin
					cur_rhs_q  <= rsp.res;
					cur_diag_q <= diag_rd_q;
				end
			end
			default: ;
		endcase
	end

	// Row stores: write at the row count, read one row below the walk index
	always_ff @(posedge clk) begin
		if (state_q == C_WR) begin
			diag_mem[cnt_q] <= ndiag_q;
			rhs_mem[cnt_q]  <= nrhs_q;
			sup_mem[cnt_q]  <= row_sup;
		end
		diag_rd_q <= diag_mem[rd_addr];
		rhs_rd_q  <= rhs_mem[rd_addr];
		sup_rd_q  <= sup_mem[rd_addr];
	end

	// Solution store: filled during back substitution, drained from the last row down
	always_ff @(posedge clk) begin
		if (state_q == C_BX && rsp.done)
			sol_mem[bi_q] <= rsp.res;
		sol_rd_q <= sol_mem[bi_q];
	end

endmodule
